/* hdl/cigar_sequence_expander_top_defines.svh */
// Assertion macros shared by the checker of the CIGAR sequence expander.
`ifndef CIGAR_SEQUENCE_EXPANDER_TOP_DEFINES_SVH
`define CIGAR_SEQUENCE_EXPANDER_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define CSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CSE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/cse_pkg.sv */
// Shared types, constants and codes of the CIGAR sequence expander.
package cse_pkg;

   localparam int OP_LEN_BITS  = 28;
   localparam int CNT_BITS     = 28;
   localparam int LEN_EFF_BITS = (OP_LEN_BITS < CNT_BITS) ? OP_LEN_BITS : CNT_BITS;
   localparam int SUM_BITS     = CNT_BITS + 4;
   localparam logic [SUM_BITS-1:0] LEN_MAX =
      SUM_BITS'((64'd1 << LEN_EFF_BITS) - 64'd1);

   localparam int SYM_BITS    = 8;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_DELETION_FILL = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PAD_FILL      = 1'b1;

   localparam logic [SYM_BITS-1:0] DELETION_FILL_RESET = 8'd95;
   localparam logic [SYM_BITS-1:0] PAD_FILL_RESET      = 8'd45;

   localparam logic CMD_CIGAR = 1'b0;
   localparam logic CMD_BASE  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_OP   = 2'd1,
      ST_ORDER    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CLS_BASE  = 3'd0,
      CLS_DIGIT = 3'd1,
      CLS_COPY  = 3'd2,
      CLS_DEL   = 3'd3,
      CLS_PAD   = 3'd4,
      CLS_BAD   = 3'd5
   } class_type;

   typedef struct packed {
      class_type           cls;
      logic [3:0]          digit;
      logic [SYM_BITS-1:0] symbol;
   } entry_type;

endpackage

/* hdl/cse_front.sv */
// Front end: takes input items and classifies each one for the back end.
module cse_front
   import cse_pkg::*;
(
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [SYM_BITS-1:0] req_symbol,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   class_type           cls;
   logic [SYM_BITS-1:0] digit_full;

   always_comb begin
      if (req_cmd == CMD_BASE) begin
         cls = CLS_BASE;
      end else begin
         case (req_symbol) inside
            ["0":"9"]:                cls = CLS_DIGIT;
            "M", "=", "X", "I", "S":  cls = CLS_COPY;
            "D", "N":                 cls = CLS_DEL;
            "H", "P":                 cls = CLS_PAD;
            default:                  cls = CLS_BAD;
         endcase
      end
   end

   assign digit_full     = req_symbol - SYM_BITS'("0");
   assign q_entry.cls    = cls;
   assign q_entry.digit  = digit_full[3:0];
   assign q_entry.symbol = req_symbol;
   assign req_stall      = q_full;
   assign q_push         = req_valid && !q_full;

endmodule

/* hdl/cse_fifo.sv */
// Short queue of classified items between the front end and the back end.
module cse_fifo
   import cse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]  count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_BITS'(1);
   endfunction

   assign full       = (count_ff == FILL_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FILL_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/cse_back.sv */
// Back end: runs the length and base counters and drives the result register.
module cse_back
   import cse_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [SYM_BITS-1:0]     csr_wdata,
   input  logic                    head_valid,
   input  entry_type               head_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SYM_BITS-1:0]     rsp_out_char,
   output logic [CNT_BITS-1:0]     rsp_repeat_count,
   output logic [1:0]              rsp_status
);

   logic [SYM_BITS-1:0] deletion_fill_ff, deletion_fill_in;
   logic [SYM_BITS-1:0] pad_fill_ff, pad_fill_in;
   logic [CNT_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0] bases_ff, bases_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYM_BITS-1:0] out_char_ff, out_char_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   status_type          status_ff, status_in;

   logic [SUM_BITS-1:0] acc_wide;
   logic [SUM_BITS-1:0] next_len;
   logic                emit;
   logic [SYM_BITS-1:0] e_char;
   logic [CNT_BITS-1:0] e_count;
   status_type          e_status;

   assign pop      = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign acc_wide = SUM_BITS'(acc_ff);
   assign next_len = (acc_wide << 3) + (acc_wide << 1) + SUM_BITS'(head_entry.digit);

   always_comb begin
      acc_in   = acc_ff;
      bases_in = bases_ff;
      emit     = 1'b0;
      e_char   = '0;
      e_count  = '0;
      e_status = ST_OK;
      if (head_entry.cls == CLS_BASE) begin
         emit = 1'b1;
         if (bases_ff == '0) begin
            e_status = ST_ORDER;
         end else begin
            bases_in = bases_ff - CNT_BITS'(1);
            e_char   = head_entry.symbol;
            e_count  = CNT_BITS'(1);
         end
      end else if (bases_ff != '0) begin
         bases_in = '0;
         acc_in   = '0;
         emit     = 1'b1;
         e_status = ST_ORDER;
      end else if (head_entry.cls == CLS_DIGIT) begin
         if (next_len > LEN_MAX) begin
            acc_in   = '0;
            emit     = 1'b1;
            e_status = ST_OVERFLOW;
         end else begin
            acc_in = next_len[CNT_BITS-1:0];
         end
      end else begin
         acc_in = '0;
         case (head_entry.cls)
            CLS_COPY: begin
               bases_in = acc_ff;
            end
            CLS_DEL: begin
               emit    = (acc_ff != '0);
               e_char  = deletion_fill_ff;
               e_count = acc_ff;
            end
            CLS_PAD: begin
               emit    = (acc_ff != '0);
               e_char  = pad_fill_ff;
               e_count = acc_ff;
            end
            default: begin
               emit     = 1'b1;
               e_status = ST_BAD_OP;
            end
         endcase
      end
   end

   always_comb begin
      deletion_fill_in = deletion_fill_ff;
      pad_fill_in      = pad_fill_ff;
      if (csr_write && csr_index == REG_DELETION_FILL) begin
         deletion_fill_in = csr_wdata;
      end
      if (csr_write && csr_index == REG_PAD_FILL) begin
         pad_fill_in = csr_wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_char_in  = out_char_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      if (pop) begin
         rsp_valid_in = emit;
         if (emit) begin
            out_char_in = e_char;
            count_in    = e_count;
            status_in   = e_status;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deletion_fill_ff <= DELETION_FILL_RESET;
         pad_fill_ff      <= PAD_FILL_RESET;
         acc_ff           <= '0;
         bases_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         deletion_fill_ff <= deletion_fill_in;
         pad_fill_ff      <= pad_fill_in;
         acc_ff           <= pop ? acc_in : acc_ff;
         bases_ff         <= pop ? bases_in : bases_ff;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      count_ff    <= count_in;
      status_ff   <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_repeat_count = count_ff;
   assign rsp_status       = status_ff;

endmodule

/* hdl/cigar_sequence_expander_top.sv */
// Top level of the CIGAR sequence expander: front end, item queue and back end.
// An accepted item is written into the queue; from the queue head the back end
// takes it and registers its result, if any, in the result register.
// Throughput is one item per cycle while the result output is not stalled.
// Synchronous reset empties the queue, clears both counters and the result
// valid flag, and loads the fill registers with 95 and 45.
module cigar_sequence_expander_top
   import cse_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [SYM_BITS-1:0]     csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  logic [SYM_BITS-1:0]     req_symbol,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SYM_BITS-1:0]     rsp_out_char,
   output logic [CNT_BITS-1:0]     rsp_repeat_count,
   output logic [1:0]              rsp_status
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_head_valid;
   entry_type q_push_entry;
   entry_type q_head_entry;

   cse_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_symbol (req_symbol),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   cse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   cse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .head_valid       (q_head_valid),
      .head_entry       (q_head_entry),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_status       (rsp_status)
   );

endmodule

/* hdl/cse_checker.sv */
// Port-level checker of the CIGAR sequence expander and its bind statement.
`include "cigar_sequence_expander_top_defines.svh"

module cse_checker
   import cse_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SYM_BITS-1:0]     rsp_out_char,
   input logic [CNT_BITS-1:0]     rsp_repeat_count,
   input logic [1:0]              rsp_status
);

   logic [SYM_BITS+CNT_BITS-1:0] rsp_data;
   logic [SYM_BITS+CNT_BITS+1:0] rsp_bits;
   logic                         rsp_wait;
   logic                         rsp_err;
   logic                         rsp_ok;
   logic                         idle_out;

   assign rsp_data = {rsp_out_char, rsp_repeat_count};
   assign rsp_bits = {rsp_data, rsp_status};
   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_err  = rsp_valid && (rsp_status != ST_OK);
   assign rsp_ok   = rsp_valid && (rsp_status == ST_OK);
   assign idle_out = !rsp_valid && !req_stall;

   `CSE_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_bits), "Stalled item changed.")
   `CSE_ASSERT(a_err_zero, rsp_err |-> rsp_data == '0, "Error item carries data.")
   `CSE_ASSERT(a_ok_count, rsp_ok |-> rsp_repeat_count != '0, "Good item has a zero count.")
   `CSE_ASSERT_ALWAYS(a_reset_out, $past(reset) && !reset |-> idle_out, "Not empty after reset.")

endmodule

bind cigar_sequence_expander_top cse_checker u_cse_checker (.*);
